### rtl/xt256_pkg.sv
// Types, palette constants and helpers for the xterm 256-color nearest-match block.
// Used by rgb_to_xterm256_nearest; no dependencies.
package xt256_pkg;

	// Number of palette entries implemented
	localparam int PALETTE_SIZE = 256;

	// Palette layout
	localparam int SYS_COUNT   = 16;
	localparam int CUBE_BASE   = 16;
	localparam int CUBE_COUNT  = 216;
	localparam int CUBE_LEVELS = 6;
	localparam int GREY_BASE   = 232;
	localparam int GREY_COUNT  = 24;

	// Distance width: one bit above the largest real distance marks an excluded entry
	localparam int DIST_W = 19;
	localparam logic [DIST_W-1:0] DIST_NONE = '1;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// Candidate: distance and palette index
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [7:0]        idx;
	} cand_t;

	// Per-channel minimum over cube levels
	typedef struct packed {
		logic [15:0] val;
		logic [2:0]  lvl;
	} chmin_t;

	// Squared distances of one channel to the six cube levels
	typedef logic [CUBE_LEVELS-1:0][15:0] sq6_t;

	localparam rgb_t SYS_RGB [SYS_COUNT] = '{
		'{8'd0,   8'd0,   8'd0  }, '{8'd205, 8'd0,   8'd0  },
		'{8'd0,   8'd205, 8'd0  }, '{8'd205, 8'd205, 8'd0  },
		'{8'd0,   8'd0,   8'd238}, '{8'd205, 8'd0,   8'd205},
		'{8'd0,   8'd205, 8'd205}, '{8'd229, 8'd229, 8'd229},
		'{8'd127, 8'd127, 8'd127}, '{8'd255, 8'd0,   8'd0  },
		'{8'd0,   8'd255, 8'd0  }, '{8'd255, 8'd255, 8'd0  },
		'{8'd92,  8'd92,  8'd255}, '{8'd255, 8'd0,   8'd255},
		'{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}
	};

	localparam logic [7:0] CUBE_LVL [CUBE_LEVELS] = '{
		8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
	};

	// Squared difference of two 8-bit values
	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return {8'd0, d} * {8'd0, d};
	endfunction

	// Lower of two candidates; the first one wins a tie (it has the lower index)
	function automatic cand_t cand_min(input cand_t a, input cand_t b);
		return (b.distance < a.distance) ? b : a;
	endfunction

	// Minimum over the first k cube levels of one channel, lowest level on a tie
	function automatic chmin_t prefix_min(input sq6_t sq, input logic [2:0] k);
		chmin_t m;
		m.val = sq[0];
		m.lvl = 3'd0;
		for (int j = 1; j < CUBE_LEVELS; j++) begin
			if ((3'(j) < k) && (sq[j] < m.val)) begin
				m.val = sq[j];
				m.lvl = 3'(j);
			end
		end
		return m;
	endfunction

	// Palette index of cube digits (red, green, blue)
	function automatic logic [7:0] cube_index(input logic [2:0] a, input logic [2:0] g,
			input logic [2:0] b);
		return 8'(CUBE_BASE) + 8'(a) * 8'd36 + 8'(g) * 8'd6 + 8'(b);
	endfunction

endpackage

### rtl/rgb_to_xterm256_nearest.sv
// Nearest xterm 256-color palette match, six-stage pipeline.
// Depends on xt256_pkg (palette constants, candidate types and helpers).
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: red[7:0], green[15:8], blue[23:16]
// m_*       out  m_tvalid/m_tready  m_tdata: palette_index[7:0], best_distance[25:8]
// cfg_*     in   cfg_valid/cfg_ready cfg_data: search_limit[8:0]
//
// One pixel per clock while m_tready holds; each pixel passes through six register
// stages before m_tvalid rises for its result.
// The cube is searched per channel (distance is separable), with the search limit
// cutting it into at most three rectangular groups; system and grey entries are
// compared directly and reduced through a registered tree.
// arst_n clears valid bits and sets search_limit to 256; cfg_ready is always high.
// Each stage holds while the next one is full and stalled; bubbles are squeezed out.
module rgb_to_xterm256_nearest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // palette_index[7:0], best_distance[25:8], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data   // search_limit[8:0]
);

	localparam int NS = xt256_pkg::SYS_COUNT;
	localparam int NG = xt256_pkg::GREY_COUNT;
	localparam int NL = xt256_pkg::CUBE_LEVELS;

	// Configuration register
	logic [8:0] search_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_limit_q <= 9'd256;
		end else if (cfg_valid) begin
			search_limit_q <= cfg_data;
		end
	end

	// Stage enables: a stage loads when it is empty or the next one loads
	logic v1, v2, v3, v4, v5, v6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = ~v6 | m_tready;
	assign en5 = ~v5 | en6;
	assign en4 = ~v4 | en5;
	assign en3 = ~v3 | en4;
	assign en2 = ~v2 | en3;
	assign en1 = ~v1 | en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
		end else begin
			if (en1) v1 <= s_tvalid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4;
			if (en6) v6 <= v5;
		end
	end

	// ---------------- Stage 1: input and effective limit ----------------
	xt256_pkg::rgb_t px_s1;
	logic [8:0]      lim_s1;
	logic [8:0]      lim_eff;

	always_comb begin
		if (search_limit_q == 9'd0) begin
			lim_eff = 9'd1;
		end else if (search_limit_q > 9'(xt256_pkg::PALETTE_SIZE)) begin
			lim_eff = 9'(xt256_pkg::PALETTE_SIZE);
		end else begin
			lim_eff = search_limit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1.r <= s_tdata[7:0];
			px_s1.g <= s_tdata[15:8];
			px_s1.b <= s_tdata[23:16];
			lim_s1  <= lim_eff;
		end
	end

	// ---------------- Stage 2: squares and limit decode ----------------
	// Cube entries searched: cn = 36*a0 + 6*b0 + c0
	logic [7:0] cn;
	logic [2:0] a0_c, b0_c, c0_c;
	logic [5:0] rem1;

	always_comb begin
		if (lim_s1 > 9'(xt256_pkg::GREY_BASE)) begin
			cn = 8'(xt256_pkg::CUBE_COUNT);
		end else if (lim_s1 > 9'(xt256_pkg::CUBE_BASE)) begin
			cn = 8'(lim_s1 - 9'(xt256_pkg::CUBE_BASE));
		end else begin
			cn = 8'd0;
		end
		a0_c = 3'd0;
		for (int k = 1; k <= NL; k++) begin
			if (cn >= 8'(36 * k)) a0_c = 3'(k);
		end
		rem1 = 6'(cn - 8'(a0_c) * 8'd36);
		b0_c = 3'd0;
		for (int k = 1; k < NL; k++) begin
			if (rem1 >= 6'(6 * k)) b0_c = 3'(k);
		end
		c0_c = 3'(rem1 - 6'(b0_c) * 6'd6);
	end

	xt256_pkg::sq6_t sq_r_s2, sq_g_s2, sq_b_s2;
	logic [15:0]     sys_sq_s2  [NS][3];
	logic [15:0]     grey_sq_s2 [NG][3];
	logic [NS-1:0]   sys_ok_s2;
	logic [NG-1:0]   grey_ok_s2;
	logic [2:0]      a0_s2, b0_s2, c0_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int j = 0; j < NL; j++) begin
				sq_r_s2[j] <= xt256_pkg::sq_diff(px_s1.r, xt256_pkg::CUBE_LVL[j]);
				sq_g_s2[j] <= xt256_pkg::sq_diff(px_s1.g, xt256_pkg::CUBE_LVL[j]);
				sq_b_s2[j] <= xt256_pkg::sq_diff(px_s1.b, xt256_pkg::CUBE_LVL[j]);
			end
			for (int i = 0; i < NS; i++) begin
				sys_sq_s2[i][0] <= xt256_pkg::sq_diff(px_s1.r, xt256_pkg::SYS_RGB[i].r);
				sys_sq_s2[i][1] <= xt256_pkg::sq_diff(px_s1.g, xt256_pkg::SYS_RGB[i].g);
				sys_sq_s2[i][2] <= xt256_pkg::sq_diff(px_s1.b, xt256_pkg::SYS_RGB[i].b);
				sys_ok_s2[i]    <= 9'(i) < lim_s1;
			end
			for (int j = 0; j < NG; j++) begin
				grey_sq_s2[j][0] <= xt256_pkg::sq_diff(px_s1.r, 8'(8 + 10 * j));
				grey_sq_s2[j][1] <= xt256_pkg::sq_diff(px_s1.g, 8'(8 + 10 * j));
				grey_sq_s2[j][2] <= xt256_pkg::sq_diff(px_s1.b, 8'(8 + 10 * j));
				grey_ok_s2[j]    <= 9'(xt256_pkg::GREY_BASE + j) < lim_s1;
			end
			a0_s2 <= a0_c;
			b0_s2 <= b0_c;
			c0_s2 <= c0_c;
		end
	end

	// ---------------- Stage 3: distance sums, per-channel cube minima ----------------
	logic [xt256_pkg::DIST_W-1:0] sys_d_s3  [NS];
	logic [xt256_pkg::DIST_W-1:0] grey_d_s3 [NG];
	xt256_pkg::chmin_t r_pre_s3, g_pre_s3, g_full_s3, b_full_s3, b_pre_s3;
	logic [15:0]       r_at_s3, g_at_s3;
	logic [2:0]        a0_s3, b0_s3;
	logic              c1_ok_s3, c2_ok_s3, c3_ok_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < NS; i++) begin
				sys_d_s3[i] <= sys_ok_s2[i] ?
					(19'(sys_sq_s2[i][0]) + 19'(sys_sq_s2[i][1]) + 19'(sys_sq_s2[i][2])) :
					xt256_pkg::DIST_NONE;
			end
			for (int j = 0; j < NG; j++) begin
				grey_d_s3[j] <= grey_ok_s2[j] ?
					(19'(grey_sq_s2[j][0]) + 19'(grey_sq_s2[j][1]) + 19'(grey_sq_s2[j][2])) :
					xt256_pkg::DIST_NONE;
			end
			r_pre_s3  <= xt256_pkg::prefix_min(sq_r_s2, a0_s2);
			g_pre_s3  <= xt256_pkg::prefix_min(sq_g_s2, b0_s2);
			g_full_s3 <= xt256_pkg::prefix_min(sq_g_s2, 3'(NL));
			b_full_s3 <= xt256_pkg::prefix_min(sq_b_s2, 3'(NL));
			b_pre_s3  <= xt256_pkg::prefix_min(sq_b_s2, c0_s2);
			// a0 reaches 6 only when the whole cube is searched; then only group one counts
			r_at_s3   <= (a0_s2 < 3'(NL)) ? sq_r_s2[a0_s2] : 16'd0;
			g_at_s3   <= sq_g_s2[b0_s2];
			a0_s3     <= a0_s2;
			b0_s3     <= b0_s2;
			c1_ok_s3  <= a0_s2 != 3'd0;
			c2_ok_s3  <= (a0_s2 < 3'(NL)) && (b0_s2 != 3'd0);
			c3_ok_s3  <= (a0_s2 < 3'(NL)) && (c0_s2 != 3'd0);
		end
	end

	// ---------------- Stage 4: cube group candidates, first tree level ----------------
	localparam int SG = NS / 4;
	localparam int GG = NG / 4;

	xt256_pkg::cand_t cube_c_s4 [3];
	xt256_pkg::cand_t sys_g_s4  [SG];
	xt256_pkg::cand_t grey_g_s4 [GG];
	xt256_pkg::cand_t sys_g_c   [SG];
	xt256_pkg::cand_t grey_g_c  [GG];
	xt256_pkg::cand_t cube_c_c  [3];

	always_comb begin
		for (int g = 0; g < SG; g++) begin
			sys_g_c[g] = '{distance: sys_d_s3[4 * g], idx: 8'(4 * g)};
			for (int k = 1; k < 4; k++) begin
				sys_g_c[g] = xt256_pkg::cand_min(sys_g_c[g],
					'{distance: sys_d_s3[4 * g + k], idx: 8'(4 * g + k)});
			end
		end
		for (int g = 0; g < GG; g++) begin
			grey_g_c[g] = '{distance: grey_d_s3[4 * g],
				idx: 8'(xt256_pkg::GREY_BASE + 4 * g)};
			for (int k = 1; k < 4; k++) begin
				grey_g_c[g] = xt256_pkg::cand_min(grey_g_c[g],
					'{distance: grey_d_s3[4 * g + k],
					idx: 8'(xt256_pkg::GREY_BASE + 4 * g + k)});
			end
		end
		// Group one: red below a0, green and blue free
		cube_c_c[0].distance = c1_ok_s3 ?
			(19'(r_pre_s3.val) + 19'(g_full_s3.val) + 19'(b_full_s3.val)) :
			xt256_pkg::DIST_NONE;
		cube_c_c[0].idx  = xt256_pkg::cube_index(r_pre_s3.lvl, g_full_s3.lvl, b_full_s3.lvl);
		// Group two: red at a0, green below b0, blue free
		cube_c_c[1].distance = c2_ok_s3 ?
			(19'(r_at_s3) + 19'(g_pre_s3.val) + 19'(b_full_s3.val)) :
			xt256_pkg::DIST_NONE;
		cube_c_c[1].idx  = xt256_pkg::cube_index(a0_s3, g_pre_s3.lvl, b_full_s3.lvl);
		// Group three: red at a0, green at b0, blue below c0
		cube_c_c[2].distance = c3_ok_s3 ?
			(19'(r_at_s3) + 19'(g_at_s3) + 19'(b_pre_s3.val)) :
			xt256_pkg::DIST_NONE;
		cube_c_c[2].idx  = xt256_pkg::cube_index(a0_s3, b0_s3, b_pre_s3.lvl);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			sys_g_s4  <= sys_g_c;
			grey_g_s4 <= grey_g_c;
			cube_c_s4 <= cube_c_c;
		end
	end

	// ---------------- Stage 5: best of each palette region ----------------
	xt256_pkg::cand_t sys_b_s5, cube_b_s5, grey_b_s5;
	xt256_pkg::cand_t sys_b_c, cube_b_c, grey_b_c;

	always_comb begin
		sys_b_c = sys_g_s4[0];
		for (int g = 1; g < SG; g++) begin
			sys_b_c = xt256_pkg::cand_min(sys_b_c, sys_g_s4[g]);
		end
		grey_b_c = grey_g_s4[0];
		for (int g = 1; g < GG; g++) begin
			grey_b_c = xt256_pkg::cand_min(grey_b_c, grey_g_s4[g]);
		end
		cube_b_c = xt256_pkg::cand_min(xt256_pkg::cand_min(cube_c_s4[0], cube_c_s4[1]),
			cube_c_s4[2]);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			sys_b_s5  <= sys_b_c;
			cube_b_s5 <= cube_b_c;
			grey_b_s5 <= grey_b_c;
		end
	end

	// ---------------- Stage 6: final pick, output register ----------------
	xt256_pkg::cand_t best_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			best_s6 <= xt256_pkg::cand_min(xt256_pkg::cand_min(sys_b_s5, cube_b_s5),
				grey_b_s5);
		end
	end

	assign m_tvalid = v6;
	assign m_tdata  = {6'd0, best_s6.distance[17:0], best_s6.idx};

endmodule

### tb/rgb_to_xterm256_nearest_test.sv
// Self-checking testbench for rgb_to_xterm256_nearest: streams RGB pixels and compares each
// palette match against a brute-force palette search kept in the bench.
// Depends on xt256_pkg (rgb_t, PALETTE_SIZE) and the rgb_to_xterm256_nearest RTL.
`timescale 1ns / 1ps

module rgb_to_xterm256_nearest_test;

	localparam int LATENCY         = 6;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int PIXELS_PER_PHASE = 38;

	// Search-limit sweep for the random phases; the last slot gets a random value
	localparam int unsigned PHASE_LIMITS [12] = '{
		256, 1, 8, 16, 232, 511, 0, 231, 255, 257, 17, 128
	};

	// Fixed system colors, {red, green, blue}
	localparam logic [23:0] SYSTEM_COLORS [16] = '{
		24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
		24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
		24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
		24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
	};
	localparam logic [7:0] CUBE_STEPS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

	typedef struct {
		logic [7:0]  index;
		logic [17:0] distance;
	} match_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // palette_index[7:0], best_distance[25:8], zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [8:0]  cfg_data;  // search_limit[8:0]

	match_t      pending_matches[$];
	int unsigned limit_shadow;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;
	bit          failed;

	rgb_to_xterm256_nearest dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Color of one palette entry
	function automatic xt256_pkg::rgb_t palette_color(input int unsigned idx);
		xt256_pkg::rgb_t c;
		int unsigned     n;
		logic [7:0]      v;
		if (idx < 16) begin
			c = SYSTEM_COLORS[idx];
		end else if (idx < 232) begin
			n = idx - 16;
			c.r = CUBE_STEPS[n / 36];
			c.g = CUBE_STEPS[(n / 6) % 6];
			c.b = CUBE_STEPS[n % 6];
		end else begin
			v = 8'(8 + (idx - 232) * 10);
			c = {v, v, v};
		end
		return c;
	endfunction

	// Exhaustive nearest-entry search; strict compare keeps the lowest index on ties
	function automatic match_t nearest_match(input xt256_pkg::rgb_t px,
			input int unsigned limit);
		match_t          m;
		xt256_pkg::rgb_t c;
		int unsigned     span;
		int unsigned     best;
		int unsigned     d;
		int              dr, dg, db;
		span = (limit == 0) ? 1 : limit;
		if (span > xt256_pkg::PALETTE_SIZE)
			span = xt256_pkg::PALETTE_SIZE;
		best = 32'hFFFF_FFFF;
		m.index = '0;
		for (int i = 0; i < span; i++) begin
			c = palette_color(i);
			dr = int'(px.r) - int'(c.r);
			dg = int'(px.g) - int'(c.g);
			db = int'(px.b) - int'(c.b);
			d = dr * dr + dg * dg + db * db;
			if (d < best) begin
				best = d;
				m.index = 8'(i);
			end
		end
		m.distance = 18'(best);
		return m;
	endfunction

	// Small random offset around a channel value, clamped to 0..255
	function automatic logic [7:0] jitter(input logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// Mix of uniform colors, greys, near-palette colors and midpoints (tie hunting)
	function automatic xt256_pkg::rgb_t random_pixel();
		xt256_pkg::rgb_t px, a, b;
		logic [7:0]      v;
		case ($urandom_range(3))
			0: begin
				px = 24'($urandom);
			end
			1: begin
				v = 8'($urandom_range(255));
				px = {v, v, v};
			end
			2: begin
				a = palette_color($urandom_range(255));
				px = {jitter(a.r), jitter(a.g), jitter(a.b)};
			end
			default: begin
				a = palette_color($urandom_range(255));
				b = palette_color($urandom_range(255));
				px.r = 8'((9'(a.r) + 9'(b.r)) >> 1);
				px.g = 8'((9'(a.g) + 9'(b.g)) >> 1);
				px.b = 8'((9'(a.b) + 9'(b.b)) >> 1);
			end
		endcase
		return px;
	endfunction

	// One pixel transfer; valid stays high afterwards so back-to-back pixels stream
	task automatic send_pixel(input xt256_pkg::rgb_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {px.b, px.g, px.r};
		do @(posedge clk); while (!s_tready);
		pending_matches.push_back(nearest_match(px, limit_shadow));
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
	endtask

	// Register write once every pending match has come back
	task automatic write_search_limit(input logic [8:0] value);
		@(posedge clk);
		while (pending_matches.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_shadow = value;
	endtask

	// Exact palette colors, channel extremes and tie points at the reset limit
	task automatic test_palette_points();
		xt256_pkg::rgb_t points [15];
		points = '{
			24'h000000, 24'hFFFFFF, 24'hCD0000, 24'h0000EE, 24'hE5E5E5,
			24'h7F7F7F, 24'h5C5CFF, 24'hFF0000, 24'h5F87AF, 24'h080808,
			24'hEEEEEE, 24'h0D0D0D, 24'h737373, 24'h557F2A, 24'hAA55D5
		};
		foreach (points[i])
			send_pixel(points[i]);
		end_burst();
	endtask

	// Zero limit (entry 0 only), limit past the palette, basic eight colors
	task automatic test_limit_extremes();
		write_search_limit(9'd0);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h123456);
		end_burst();
		write_search_limit(9'd511);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h7F7F7F);
		end_burst();
		write_search_limit(9'd8);
		send_pixel(24'h5C5CFF);
		send_pixel(24'hE5E5E5);
		end_burst();
	endtask

	// Random pixels over four limit settings under one idling profile
	task automatic test_random_stream(input int unsigned idle_pct, input int unsigned stall_pct,
			inout int unsigned limit_slot);
		int unsigned lim;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int phase = 0; phase < 4; phase++) begin
			lim = (limit_slot == 11) ? $urandom_range(511) : PHASE_LIMITS[limit_slot];
			limit_slot++;
			write_search_limit(9'(lim));
			for (int k = 0; k < PIXELS_PER_PHASE; k++)
				send_pixel(random_pixel());
			end_burst();
		end
	endtask

	// Result checker
	always @(posedge clk) begin : check_results
		match_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_matches.size() == 0) begin
				failed = 1'b1;
				$display("%0t: unexpected result: expected none, actual index %0d distance %0d",
					$time, m_tdata[7:0], m_tdata[25:8]);
			end else begin
				want = pending_matches.pop_front();
				if (m_tdata[7:0] !== want.index || m_tdata[25:8] !== want.distance) begin
					failed = 1'b1;
					$display("%0t: mismatch: expected index %0d distance %0d, %s %0d %s %0d",
						$time, want.index, want.distance, "actual index", m_tdata[7:0],
						"distance", m_tdata[25:8]);
				end
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : run_tests
		int unsigned limit_slot;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		limit_shadow   = 256;
		send_idle_pct  = 16;
		recv_stall_pct = 79;
		quiet_cycles   = 0;
		failed         = 1'b0;
		limit_slot     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_palette_points();
		test_limit_extremes();
		test_random_stream(16, 79, limit_slot);
		test_random_stream(79, 16, limit_slot);
		test_random_stream(0, 0, limit_slot);

		// Drain, then give stray results time to show up
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);
		if (failed) begin
			$display("Simulation FAILED");
		end else begin
			$display("Simulation PASSED");
		end
		$finish;
	end

endmodule
